>>> src/gkm_pkg.sv
`timescale 1ns / 1ps
// Package for the Gaussian kernel matrix entry block: request and result
// structs, register indexes, status codes, pipeline sizes and helpers.
// No dependencies.
package gkm_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_FIRST  = 2'd0,
    REG_GRID_LAST   = 2'd1,
    REG_FIRST_WIDTH = 2'd2,
    REG_LAST_WIDTH  = 2'd3
  } gkm_reg_e;

  // Reset values of the registers
  localparam logic [31:0] GRID_FIRST_RST  = 32'd0;
  localparam logic [31:0] GRID_LAST_RST   = 32'd65536;
  localparam logic [30:0] FIRST_WIDTH_RST = 31'd65536;
  localparam logic [30:0] LAST_WIDTH_RST  = 31'd65536;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SPAN_ZERO = 2'd1;
  localparam logic [1:0] STATUS_BAD_WIDTH = 2'd2;

  typedef struct packed {
    logic signed [31:0] row_position;
    logic signed [31:0] column_position;
  } gkm_req_t;

  typedef struct packed {
    logic [16:0] kernel_value;
    logic [1:0]  status;
  } gkm_res_t;

  // Exception flags that travel with a request
  typedef struct packed {
    logic span_zero;
    logic bad_width;
    logic underflow;
  } gkm_flags_t;

  // Pipeline sizes
  localparam int unsigned DIV1_STEPS   = 64;  // interpolation quotient bits
  localparam int unsigned DIV2_STEPS   = 31;  // normalized distance bits
  localparam int unsigned TAYLOR_TERMS = 6;
  localparam int unsigned SQUARE_STEPS = 7;
  localparam int unsigned PIPE_DEPTH   = 4 + DIV1_STEPS + 3 + DIV2_STEPS + 1
                                         + 2 * TAYLOR_TERMS + SQUARE_STEPS + 1;

  // 1.0 in Q.32
  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

  // Reciprocals for exact floor division of values below 2^29
  localparam logic [29:0]  RECIP3    = 30'd715827883;
  localparam int unsigned  RECIP3_SH = 31;
  localparam logic [29:0]  RECIP5    = 30'd858993460;
  localparam int unsigned  RECIP5_SH = 32;

  // floor(x / k) for the Taylor denominators 1 to 6
  function automatic logic [28:0] div_small(input logic [28:0] x, input int unsigned k);
    logic [58:0] p3;
    logic [58:0] p5;
    logic [58:0] p6;
    logic [28:0] q;
    p3 = 59'(x) * 59'(RECIP3);
    p5 = 59'(x) * 59'(RECIP5);
    p6 = 59'(x[28:1]) * 59'(RECIP3);
    case (k)
      1:       q = x;
      2:       q = x >> 1;
      3:       q = 29'(p3 >> RECIP3_SH);
      4:       q = x >> 2;
      5:       q = 29'(p5 >> RECIP5_SH);
      6:       q = 29'(p6 >> RECIP3_SH);
      default: q = x;
    endcase
    return q;
  endfunction

endpackage

>>> src/gaussian_kernel_matrix_entry.sv
`timescale 1ns / 1ps
// Top level of the Gaussian kernel matrix entry block: width interpolation,
// normalized distance and exp(-u^2/2) in one deep pipeline. Uses gkm_pkg.
//
// Usage:
//   The request channel (in_valid_i / in_ready_o / in_data_i) carries a row
//   and a column position, signed Q15.16. The result channel (out_valid_o /
//   out_ready_i / out_data_o) returns one kernel value (unsigned Q0.16,
//   65536 is 1.0) and a status for every request, in request order.
//   Throughput is one request per cycle while the skid register is empty.
//   The pipeline has 123 register stages: 4 input stages, 64 stages of the
//   bit-per-stage interpolation divider, 3 width stages, 31 stages of the
//   distance divider, 1 squaring stage, 12 Taylor stages, 7 squaring stages
//   and the result register.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the
//   user must write them only while no request is in flight, which the block
//   does not enforce. They read at reset as grid 0..1.0 with both widths
//   1.0. Reset empties the pipeline.
//   When the receiver stalls, the result moves into a one-entry skid
//   register and the whole pipeline holds until it is taken; nothing is
//   lost or repeated.
module gaussian_kernel_matrix_entry (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  gkm_pkg::gkm_req_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output gkm_pkg::gkm_res_t        out_data_o,
  input  logic                     cfg_we_i,
  input  logic [gkm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gkm_pkg::CfgDataW-1:0] cfg_data_i
);
  import gkm_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [31:0] gf_q, gl_q;
  logic [30:0] fw_q, lw_q;
  gkm_reg_e    cfg_reg;

  assign cfg_reg = gkm_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gf_q <= GRID_FIRST_RST;
      gl_q <= GRID_LAST_RST;
      fw_q <= FIRST_WIDTH_RST;
      lw_q <= LAST_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg)
        REG_GRID_FIRST:  gf_q <= cfg_data_i;
        REG_GRID_LAST:   gl_q <= cfg_data_i;
        REG_FIRST_WIDTH: fw_q <= cfg_data_i[30:0];
        REG_LAST_WIDTH:  lw_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Derived constants of the current configuration
  logic signed [32:0] span;
  logic [32:0]        span_mag;
  logic               span_neg;
  logic signed [31:0] dw;

  assign span     = $signed({gl_q[31], gl_q}) - $signed({gf_q[31], gf_q});
  assign span_neg = span[32];
  assign span_mag = span_neg ? 33'(-span) : span;
  assign dw       = $signed({1'b0, lw_q}) - $signed({1'b0, fw_q});

  // ---------------------------------------------------------------
  // Flow control: global advance, skid register at the output
  // ---------------------------------------------------------------
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;
  gkm_res_t              res_q, res_d;
  gkm_res_t              skid_q;
  logic                  skid_full_q, skid_full_d;

  assign en          = !skid_full_q;
  assign in_ready_o  = en;
  assign out_valid_o = skid_full_q || vld_q[PIPE_DEPTH-1];
  assign out_data_o  = skid_full_q ? skid_q : res_q;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // Park the last result when the receiver stalls
  always_comb begin
    skid_full_d = skid_full_q;
    if (skid_full_q && out_ready_i) begin
      skid_full_d = 1'b0;
    end else if (!skid_full_q && vld_q[PIPE_DEPTH-1] && !out_ready_i) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q && vld_q[PIPE_DEPTH-1] && !out_ready_i) begin
      skid_q <= res_q;
    end
  end

  // ---------------------------------------------------------------
  // Stages 1 to 4: offset, distance, interpolation product
  // ---------------------------------------------------------------
  logic [32:0]        diff1_q, diff1_d;
  logic [32:0]        ud1_q, ud1_d, ud2_q, ud3_q, ud4_q;
  logic [32:0]        cd;
  logic signed [16:0] hi_s, lo_s;
  logic signed [48:0] ph_q, ph_d, pl_q, pl_d;
  logic signed [64:0] p3_q, p3_d;
  logic [63:0]        mag4_q, mag4_d;
  logic               neg4_q, neg4_d;

  assign diff1_d = {in_data_i.row_position[31], in_data_i.row_position}
                 - {gf_q[31], gf_q};
  assign cd      = {in_data_i.column_position[31], in_data_i.column_position}
                 - {in_data_i.row_position[31], in_data_i.row_position};
  assign ud1_d   = cd[32] ? 33'(-cd) : cd;

  assign hi_s = $signed(diff1_q[32:16]);
  assign lo_s = $signed({1'b0, diff1_q[15:0]});
  assign ph_d = hi_s * dw;
  assign pl_d = lo_s * dw;

  assign p3_d = $signed({ph_q, 16'h0000}) + 65'(pl_q);

  assign mag4_d = p3_q[64] ? 64'(-p3_q) : p3_q[63:0];
  assign neg4_d = p3_q[64] ^ span_neg;

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff1_q <= diff1_d;
      ud1_q   <= ud1_d;
      ph_q    <= ph_d;
      pl_q    <= pl_d;
      ud2_q   <= ud1_q;
      p3_q    <= p3_d;
      ud3_q   <= ud2_q;
      mag4_q  <= mag4_d;
      neg4_q  <= neg4_d;
      ud4_q   <= ud3_q;
    end
  end

  // ---------------------------------------------------------------
  // Interpolation divider: |product| / |span|, one quotient bit a stage
  // ---------------------------------------------------------------
  logic [32:0] d1_rem_q [DIV1_STEPS];
  logic [63:0] d1_nq_q  [DIV1_STEPS];
  logic        d1_neg_q [DIV1_STEPS];
  logic [32:0] d1_ud_q  [DIV1_STEPS];

  for (genvar j = 0; j < DIV1_STEPS; j++) begin : g_div1
    logic [32:0] rem_in;
    logic [63:0] nq_in;
    logic        neg_in;
    logic [32:0] ud_in;
    logic [33:0] tr;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = mag4_q;
      assign neg_in = neg4_q;
      assign ud_in  = ud4_q;
    end else begin : g_next
      assign rem_in = d1_rem_q[j-1];
      assign nq_in  = d1_nq_q[j-1];
      assign neg_in = d1_neg_q[j-1];
      assign ud_in  = d1_ud_q[j-1];
    end

    // Trial subtract of the divisor
    assign tr = {rem_in, nq_in[63]};
    assign ge = tr >= {1'b0, span_mag};

    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_rem_q[j] <= ge ? 33'(tr - {1'b0, span_mag}) : tr[32:0];
        d1_nq_q[j]  <= {nq_in[62:0], ge};
        d1_neg_q[j] <= neg_in;
        d1_ud_q[j]  <= ud_in;
      end
    end
  end

  // ---------------------------------------------------------------
  // Width stages: sign, add first width, checks
  // ---------------------------------------------------------------
  logic signed [64:0] qs_q, qs_d;
  logic signed [64:0] width_q, width_d;
  logic [32:0]        udw1_q, udw2_q, udw3_q;
  logic [63:0]        uw;
  logic [42:0]        five_uw;
  gkm_flags_t         fl_w3_d, fl_w3_q;
  logic [63:0]        uw3_q;

  assign qs_d = d1_neg_q[DIV1_STEPS-1]
              ? -$signed({1'b0, d1_nq_q[DIV1_STEPS-1]})
              : $signed({1'b0, d1_nq_q[DIV1_STEPS-1]});
  assign width_d = qs_q + $signed({34'b0, fw_q});

  assign uw      = width_q[63:0];
  assign five_uw = {1'b0, uw[39:0], 2'b00} + 43'(uw[39:0]);

  always_comb begin
    fl_w3_d.span_zero = (span == '0);
    fl_w3_d.bad_width = width_q[64] || (width_q == '0);
    fl_w3_d.underflow = (uw[63:40] == '0) && (43'(udw2_q) >= five_uw);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qs_q    <= qs_d;
      udw1_q  <= d1_ud_q[DIV1_STEPS-1];
      width_q <= width_d;
      udw2_q  <= udw1_q;
      fl_w3_q <= fl_w3_d;
      uw3_q   <= uw;
      udw3_q  <= udw2_q;
    end
  end

  // ---------------------------------------------------------------
  // Distance divider: (|d| << 28) / width, one quotient bit a stage
  // ---------------------------------------------------------------
  logic [63:0] d2_rem_q [DIV2_STEPS];
  logic [30:0] d2_l_q   [DIV2_STEPS];
  logic [63:0] d2_uw_q  [DIV2_STEPS];
  gkm_flags_t  d2_fl_q  [DIV2_STEPS];

  for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
    logic [63:0] rem_in;
    logic [30:0] l_in;
    logic [63:0] uw_in;
    gkm_flags_t  fl_in;
    logic [64:0] tr;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in = 64'(udw3_q[32:3]);
      assign l_in   = {udw3_q[2:0], 28'h0000000};
      assign uw_in  = uw3_q;
      assign fl_in  = fl_w3_q;
    end else begin : g_next
      assign rem_in = d2_rem_q[j-1];
      assign l_in   = d2_l_q[j-1];
      assign uw_in  = d2_uw_q[j-1];
      assign fl_in  = d2_fl_q[j-1];
    end

    // Trial subtract of the width
    assign tr = {rem_in, l_in[30]};
    assign ge = tr >= {1'b0, uw_in};

    always_ff @(posedge clk_i) begin
      if (en) begin
        d2_rem_q[j] <= ge ? 64'(tr - {1'b0, uw_in}) : tr[63:0];
        d2_l_q[j]   <= {l_in[29:0], ge};
        d2_uw_q[j]  <= uw_in;
        d2_fl_q[j]  <= fl_in;
      end
    end
  end

  // ---------------------------------------------------------------
  // Exponent: g = u^2 / 2^32, that is (u^2/2) / 128 in Q.32
  // ---------------------------------------------------------------
  logic [61:0] usq;
  logic [29:0] g_q;
  gkm_flags_t  fl_g_q;

  assign usq = 62'(d2_l_q[DIV2_STEPS-1]) * 62'(d2_l_q[DIV2_STEPS-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q    <= usq[61:32];
      fl_g_q <= d2_fl_q[DIV2_STEPS-1];
    end
  end

  // ---------------------------------------------------------------
  // Taylor series of exp(-g) in Horner form, two stages a term
  // ---------------------------------------------------------------
  logic [28:0] ta_x_q  [TAYLOR_TERMS];
  logic [29:0] ta_g_q  [TAYLOR_TERMS];
  gkm_flags_t  ta_fl_q [TAYLOR_TERMS];
  logic [32:0] tb_t_q  [TAYLOR_TERMS];
  logic [29:0] tb_g_q  [TAYLOR_TERMS];
  gkm_flags_t  tb_fl_q [TAYLOR_TERMS];

  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_taylor
    localparam int unsigned K = TAYLOR_TERMS - i;
    logic [32:0] t_in;
    logic [29:0] g_in;
    gkm_flags_t  fl_in;
    logic [62:0] m;

    if (i == 0) begin : g_first
      assign t_in  = Q32_ONE;
      assign g_in  = g_q;
      assign fl_in = fl_g_q;
    end else begin : g_next
      assign t_in  = tb_t_q[i-1];
      assign g_in  = tb_g_q[i-1];
      assign fl_in = tb_fl_q[i-1];
    end

    assign m = 63'(g_in) * 63'(t_in);

    // Multiply, then divide by the term index and subtract from one
    always_ff @(posedge clk_i) begin
      if (en) begin
        ta_x_q[i]  <= m[60:32];
        ta_g_q[i]  <= g_in;
        ta_fl_q[i] <= fl_in;
        tb_t_q[i]  <= Q32_ONE - 33'(div_small(ta_x_q[i], K));
        tb_g_q[i]  <= ta_g_q[i];
        tb_fl_q[i] <= ta_fl_q[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Square seven times, rounding half up, holding at one
  // ---------------------------------------------------------------
  logic [32:0] sq_t_q  [SQUARE_STEPS];
  gkm_flags_t  sq_fl_q [SQUARE_STEPS];

  for (genvar s = 0; s < SQUARE_STEPS; s++) begin : g_square
    logic [32:0] t_in;
    gkm_flags_t  fl_in;
    logic [63:0] prod;

    if (s == 0) begin : g_first
      assign t_in  = tb_t_q[TAYLOR_TERMS-1];
      assign fl_in = tb_fl_q[TAYLOR_TERMS-1];
    end else begin : g_next
      assign t_in  = sq_t_q[s-1];
      assign fl_in = sq_fl_q[s-1];
    end

    assign prod = 64'(t_in[31:0]) * 64'(t_in[31:0]) + 64'h0000_0000_8000_0000;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_t_q[s]  <= t_in[32] ? Q32_ONE : 33'(prod[63:32]);
        sq_fl_q[s] <= fl_in;
      end
    end
  end

  // ---------------------------------------------------------------
  // Result: round to Q0.16, saturate, apply exceptions
  // ---------------------------------------------------------------
  logic [33:0] e_rnd;
  logic [17:0] v;
  logic [16:0] v_sat;
  gkm_flags_t  fl_out;

  assign e_rnd  = 34'(sq_t_q[SQUARE_STEPS-1]) + 34'h0_0000_8000;
  assign v      = e_rnd[33:16];
  assign v_sat  = (v > 18'd65536) ? 17'd65536 : v[16:0];
  assign fl_out = sq_fl_q[SQUARE_STEPS-1];

  always_comb begin
    if (fl_out.span_zero) begin
      res_d = '{kernel_value: '0, status: STATUS_SPAN_ZERO};
    end else if (fl_out.bad_width) begin
      res_d = '{kernel_value: '0, status: STATUS_BAD_WIDTH};
    end else if (fl_out.underflow) begin
      res_d = '{kernel_value: '0, status: STATUS_OK};
    end else begin
      res_d = '{kernel_value: v_sat, status: STATUS_OK};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

endmodule
